// ===== rtl/core/hnt_pkg.sv =====
// Shared types and constants for the held note tracker.
package hnt_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int FUNC_W   = 2;
  localparam int CHAN_W   = 4;
  localparam int PITCH_W  = 7;
  localparam int VEL_W    = 7;
  localparam int OUTCNT_W = 6;

  localparam logic [FUNC_W-1:0] FUNC_NOTE_ON  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_NOTE_OFF = 2'd1;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_ON,
    OP_OFF
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [CHAN_W-1:0]  channel;
    logic [PITCH_W-1:0] pitch;
  } cmd_t;

endpackage

// ===== rtl/core/hnt_front.sv =====
// Front end: classifies each request and holds it in a short command queue.
module hnt_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [hnt_pkg::FUNC_W-1:0]  in_func,
  input  logic [hnt_pkg::CHAN_W-1:0]  in_channel,
  input  logic [hnt_pkg::PITCH_W-1:0] in_pitch,
  input  logic [hnt_pkg::VEL_W-1:0]   in_velocity,
  output logic                        q_valid,
  input  logic                        q_pop,
  output hnt_pkg::cmd_t               q_head
);
  import hnt_pkg::*;

  cmd_t              q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] q_cnt_r;
  cmd_t              cmd_in;
  logic              push;
  logic              pop;

  // note-on with zero velocity counts as note-off
  always_comb begin
    cmd_in.channel = in_channel;
    cmd_in.pitch   = in_pitch;
    if (in_func == FUNC_NOTE_ON && in_velocity != '0) begin
      cmd_in.op = OP_ON;
    end else if (in_func == FUNC_NOTE_ON || in_func == FUNC_NOTE_OFF) begin
      cmd_in.op = OP_OFF;
    end else begin
      cmd_in.op = OP_NOP;
    end
  end

  assign busy    = (q_cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (q_cnt_r != '0);
  assign q_head  = q_mem_r[rd_ptr_r];
  assign push    = start && !busy;
  assign pop     = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   q_cnt_r <= q_cnt_r + 1'b1;
        2'b01:   q_cnt_r <= q_cnt_r - 1'b1;
        default: q_cnt_r <= q_cnt_r;
      endcase
    end
  end

endmodule

// ===== rtl/core/hnt_back.sv =====
// Back end: note table and the slot scan that executes queued commands.
module hnt_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  hnt_pkg::cmd_t                 q_head,
  output logic                          out_valid,
  output logic [hnt_pkg::OUTCNT_W-1:0]  out_held_count,
  output logic [hnt_pkg::OUTCNT_W-1:0]  out_removed_count,
  output logic                          out_dropped
);
  import hnt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN_ON,
    S_SCAN_OFF
  } state_t;

  state_t             state_r;
  cmd_t               cmd_r;
  logic [IDX_W-1:0]   idx_r;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   removed_r;
  logic               valid_r [TABLE_DEPTH];
  logic [CHAN_W-1:0]  chan_r  [TABLE_DEPTH];
  logic [PITCH_W-1:0] pitch_r [TABLE_DEPTH];

  logic               slot_valid;
  logic               on_hit;
  logic               off_hit;
  logic               last_slot;
  logic [CNT_W-1:0]   removed_nxt;

  assign slot_valid  = valid_r[idx_r];
  assign on_hit      = (state_r == S_SCAN_ON) && !slot_valid;
  assign off_hit     = (state_r == S_SCAN_OFF) && slot_valid &&
                       chan_r[idx_r] == cmd_r.channel && pitch_r[idx_r] == cmd_r.pitch;
  assign last_slot   = (idx_r == IDX_W'(TABLE_DEPTH - 1));
  assign removed_nxt = removed_r + CNT_W'(off_hit);
  assign q_pop       = (state_r == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (on_hit) begin
      chan_r[idx_r]  <= cmd_r.channel;
      pitch_r[idx_r] <= cmd_r.pitch;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      idx_r     <= '0;
      count_r   <= '0;
      removed_r <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cmd_r     <= q_head;
            idx_r     <= '0;
            removed_r <= '0;
            case (q_head.op)
              OP_ON: begin
                if (count_r == CNT_W'(TABLE_DEPTH)) begin
                  out_valid         <= 1'b1;
                  out_held_count    <= OUTCNT_W'(count_r);
                  out_removed_count <= '0;
                  out_dropped       <= 1'b1;
                end else begin
                  state_r <= S_SCAN_ON;
                end
              end
              OP_OFF: state_r <= S_SCAN_OFF;
              default: begin
                out_valid         <= 1'b1;
                out_held_count    <= OUTCNT_W'(count_r);
                out_removed_count <= '0;
                out_dropped       <= 1'b0;
              end
            endcase
          end
        end
        S_SCAN_ON: begin
          // a free slot exists, so the scan stops before running off the end
          if (on_hit) begin
            valid_r[idx_r]    <= 1'b1;
            count_r           <= count_r + 1'b1;
            out_valid         <= 1'b1;
            out_held_count    <= OUTCNT_W'(count_r + 1'b1);
            out_removed_count <= '0;
            out_dropped       <= 1'b0;
            state_r           <= S_IDLE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_SCAN_OFF: begin
          if (off_hit) begin
            valid_r[idx_r] <= 1'b0;
          end
          removed_r <= removed_nxt;
          idx_r     <= idx_r + 1'b1;
          if (last_slot) begin
            count_r           <= count_r - removed_nxt;
            out_valid         <= 1'b1;
            out_held_count    <= OUTCNT_W'(count_r - removed_nxt);
            out_removed_count <= OUTCNT_W'(removed_nxt);
            out_dropped       <= 1'b0;
            state_r           <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/held_note_tracker.sv =====
// Top level of the held note tracker: front end, command queue and table engine.
//
// Keeps up to TABLE_DEPTH (32) held notes as channel/pitch pairs. A request is
// taken on a clock edge with start high and busy low; busy rises only when the
// two-entry command queue between the front end and the table engine is full.
// Every request gives exactly one result, shown for a single cycle with
// out_valid high; the receiver cannot stall, so it must take it then.
// The engine handles one request at a time and walks the table one slot per
// clock, stepping as follows:
//   - other messages and dropped note-ons (table full): result straight from idle
//   - note-on: slots scanned from index 0 up to the lowest free slot
//   - note-off (or note-on with velocity zero): the whole table is scanned,
//     every slot checked, all matching entries removed
// The first engine cycle is the one in which the request leaves the queue, so
// an idle engine starts on the cycle right after the accepting edge. The result
// strobe is high in the cycle after the engine's last cycle. A request that
// finds the engine busy waits in the queue until the engine is idle again. For
// note-ons and note-offs, sustained throughput is set by the slot scan. Counts
// above 63 would wrap in the 6-bit outputs.
// After reset the table is empty and no clearing pass is needed.
module held_note_tracker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [hnt_pkg::FUNC_W-1:0]    in_func,
  input  logic [hnt_pkg::CHAN_W-1:0]    in_channel,
  input  logic [hnt_pkg::PITCH_W-1:0]   in_pitch,
  input  logic [hnt_pkg::VEL_W-1:0]     in_velocity,
  output logic                          out_valid,
  output logic [hnt_pkg::OUTCNT_W-1:0]  out_held_count,
  output logic [hnt_pkg::OUTCNT_W-1:0]  out_removed_count,
  output logic                          out_dropped
);
  import hnt_pkg::*;

  logic q_valid;
  logic q_pop;
  cmd_t q_head;

  // classify note-on / note-off / other and queue the request
  hnt_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_func     (in_func),
    .in_channel  (in_channel),
    .in_pitch    (in_pitch),
    .in_velocity (in_velocity),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_head      (q_head)
  );

  // table engine: slot scan, count update, registered result
  hnt_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_pop             (q_pop),
    .q_head            (q_head),
    .out_valid         (out_valid),
    .out_held_count    (out_held_count),
    .out_removed_count (out_removed_count),
    .out_dropped       (out_dropped)
  );

endmodule

// ===== rtl/core/hnt_checker.sv =====
// Port-level checks for the held note tracker, bound to the top level.
module hnt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic [hnt_pkg::OUTCNT_W-1:0]  out_held_count,
  input logic [hnt_pkg::OUTCNT_W-1:0]  out_removed_count,
  input logic                          out_dropped
);
  import hnt_pkg::*;

  // a drop only happens with a full table and never removes anything
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dropped |->
      out_held_count == OUTCNT_W'(TABLE_DEPTH) && out_removed_count == '0)
    else $error("dropped note-on without a full table");

  // not busy and no result right after reset
  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !busy && !out_valid)
    else $error("busy or result right after reset");

  // the queue only fills on a taken request
  a_busy_needs_request: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && !start |=> !busy)
    else $error("busy without a request");

  // a result never reports a removal and a drop together
  a_remove_or_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_removed_count != '0 |-> !out_dropped)
    else $error("result both removed and dropped");

endmodule

bind held_note_tracker hnt_checker u_hnt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_held_count    (out_held_count),
  .out_removed_count (out_removed_count),
  .out_dropped       (out_dropped)
);
